// ----- rtl/rgb565_skin_pixel_classifier_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the RGB565 skin pixel classifier
// ---------------------------------------------------------------------------
`ifndef RGB565_SKIN_PIXEL_CLASSIFIER_TOP_DEFINES_SVH
`define RGB565_SKIN_PIXEL_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RSKIN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define RSKIN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rskin_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rskin_pkg
// Types, constants and divider step for the RGB565 skin pixel classifier.
// ---------------------------------------------------------------------------
package rskin_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // quotients are 8 bits, two bits retired per divider stage
  localparam int unsigned QuoW       = 8;
  localparam int unsigned BitsPerStg = 2;
  localparam int unsigned DivStg     = QuoW / BitsPerStg;

  localparam logic [7:0] HueMax = 8'd179;

  localparam logic [8:0] DegWrap  = 9'd360;
  localparam logic [8:0] DegGreen = 9'd120;
  localparam logic [8:0] DegBlue  = 9'd240;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_VAL_LOW  = 3'd4,
    REG_VAL_HIGH = 3'd5
  } reg_idx_e;

  localparam logic [7:0] HueLowRst  = 8'd0;
  localparam logic [7:0] HueHighRst = 8'd30;
  localparam logic [7:0] SatLowRst  = 8'd15;
  localparam logic [7:0] SatHighRst = 8'd200;
  localparam logic [7:0] ValLowRst  = 8'd40;
  localparam logic [7:0] ValHighRst = 8'd255;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [15:0] pixel;
    logic        last_in;
  } pix_in_t;

  typedef struct packed {
    logic       skin;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       last_out;
  } pix_out_t;

  // divider pipeline word: saturation (divisor mx) and hue (divisor delta)
  typedef struct packed {
    logic [7:0] s_rem;
    logic [7:0] s_num;
    logic [7:0] s_quo;
    logic [7:0] h_rem;
    logic [7:0] h_num;
    logic [7:0] h_quo;
    logic [7:0] delta;
    logic [7:0] mx;
    sector_e    sector;
    logic       neg;
    logic       last;
  } div_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [8:0] div_bit(input logic [7:0] rem, input logic nb,
                                         input logic [7:0] dvs);
    logic [8:0] t;
    logic [8:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      div_bit = {1'b1, diff[7:0]};
    end else begin
      div_bit = {1'b0, t[7:0]};
    end
  endfunction

  function automatic div_t div_step(input div_t d);
    div_t       o;
    logic [8:0] rs;
    logic [8:0] rh;
    o = d;
    for (int i = 0; i < BitsPerStg; i++) begin
      rs      = div_bit(o.s_rem, o.s_num[7], o.mx);
      rh      = div_bit(o.h_rem, o.h_num[7], o.delta);
      o.s_rem = rs[7:0];
      o.s_quo = {o.s_quo[6:0], rs[8]};
      o.s_num = {o.s_num[6:0], 1'b0};
      o.h_rem = rh[7:0];
      o.h_quo = {o.h_quo[6:0], rh[8]};
      o.h_num = {o.h_num[6:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- rtl/rgb565_skin_pixel_classifier_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb565_skin_pixel_classifier_top
// RGB565 pixel to HSV with skin window test, fully pipelined.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------
//  in      | in_valid_i / in_stall_o   | pix_in_t  (pixel, last_in)
//  out     | out_valid_o / out_stall_i | pix_out_t (skin, hue, ...)
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  One pixel per cycle while no stall holds the pipeline, in these stages:
//  channel max/min, numerators, four divider stages (two quotient bits each
//  for saturation and hue), then hue offset and window compare.
//  Reset clears the stage valid bits and loads the window defaults.
//  A stall freezes only the stages that are full up to the stalled end;
//  bubbles ahead of it keep closing.
// ---------------------------------------------------------------------------
`include "rgb565_skin_pixel_classifier_top_defines.svh"

module rgb565_skin_pixel_classifier_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rskin_pkg::pix_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rskin_pkg::pix_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [rskin_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rskin_pkg::CfgDataW-1:0] cfg_data_i
);
  import rskin_pkg::*;

  localparam int unsigned NStg = DivStg + 3;

  // ---- configuration ----
  logic [7:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q, val_low_q, val_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= HueLowRst;
      hue_high_q <= HueHighRst;
      sat_low_q  <= SatLowRst;
      sat_high_q <= SatHighRst;
      val_low_q  <= ValLowRst;
      val_high_q <= ValHighRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HUE_LOW:  hue_low_q  <= cfg_data_i[7:0];
        REG_HUE_HIGH: hue_high_q <= cfg_data_i[7:0];
        REG_SAT_LOW:  sat_low_q  <= cfg_data_i[7:0];
        REG_SAT_HIGH: sat_high_q <= cfg_data_i[7:0];
        REG_VAL_LOW:  val_low_q  <= cfg_data_i[7:0];
        REG_VAL_HIGH: val_high_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline control ----
  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;
  logic [NStg-1:0] v_in;

  always_comb begin
    rdy[NStg] = !out_stall_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_in = {v_q[NStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NStg-1];

  // ---- stage 1: expand, max/min, sector, signed difference ----
  logic [7:0] r8, g8, b8, rg_max, rg_min, mx_d, mn_d;
  sector_e    sec_d;
  logic [8:0] diff_d;

  always_comb begin
    r8     = {in_data_i.pixel[15:11], 3'b000};
    g8     = {in_data_i.pixel[10:5], 2'b00};
    b8     = {in_data_i.pixel[4:0], 3'b000};
    rg_max = (r8 >= g8) ? r8 : g8;
    rg_min = (r8 <= g8) ? r8 : g8;
    mx_d   = (b8 > rg_max) ? b8 : rg_max;
    mn_d   = (b8 < rg_min) ? b8 : rg_min;
    // ties go to red, then green
    if (r8 >= g8 && r8 >= b8) begin
      sec_d  = SEC_RED;
      diff_d = {1'b0, g8} - {1'b0, b8};
    end else if (g8 >= b8) begin
      sec_d  = SEC_GREEN;
      diff_d = {1'b0, b8} - {1'b0, r8};
    end else begin
      sec_d  = SEC_BLUE;
      diff_d = {1'b0, r8} - {1'b0, g8};
    end
  end

  logic [7:0] s1_mx_q, s1_mn_q;
  sector_e    s1_sec_q;
  logic [8:0] s1_diff_q;
  logic       s1_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      s1_mx_q   <= mx_d;
      s1_mn_q   <= mn_d;
      s1_sec_q  <= sec_d;
      s1_diff_q <= diff_d;
      s1_last_q <= in_data_i.last_in;
    end
  end

  // ---- stage 2: delta and dividends ----
  logic [7:0]  delta, abs_diff;
  logic [8:0]  neg_diff;
  logic [15:0] num_s, num_h;
  div_t        div_d;

  always_comb begin
    delta    = s1_mx_q - s1_mn_q;
    neg_diff = ~s1_diff_q + 9'd1;
    abs_diff = s1_diff_q[8] ? neg_diff[7:0] : s1_diff_q[7:0];
    // 255*delta and 60*|diff|; both stay below 256*divisor, so the
    // upper byte is already a valid partial remainder
    num_s    = {delta, 8'h00} - {8'h00, delta};
    num_h    = {2'b00, abs_diff, 6'b000000} - {6'b000000, abs_diff, 2'b00};

    div_d.s_rem  = num_s[15:8];
    div_d.s_num  = num_s[7:0];
    div_d.s_quo  = '0;
    div_d.h_rem  = num_h[15:8];
    div_d.h_num  = num_h[7:0];
    div_d.h_quo  = '0;
    div_d.delta  = delta;
    div_d.mx     = s1_mx_q;
    div_d.sector = s1_sec_q;
    div_d.neg    = s1_diff_q[8];
    div_d.last   = s1_last_q;
  end

  div_t div_q [DivStg+1];

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      div_q[0] <= div_d;
    end
  end

  // ---- divider stages ----
  for (genvar k = 1; k <= DivStg; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (rdy[k+1] && v_q[k]) begin
        div_q[k] <= div_step(div_q[k-1]);
      end
    end
  end

  // ---- last stage: hue offset, halving, window test ----
  div_t       fin;
  logic       grey, neg_q;
  logic [8:0] base, deg;
  logic [7:0] hue_c, sat_c;
  pix_out_t   out_d, out_q;

  always_comb begin
    fin   = div_q[DivStg];
    grey  = (fin.delta == '0);
    // a zero quotient of a negative difference truncates to plus zero
    neg_q = fin.neg && (fin.h_quo != '0);
    case (fin.sector)
      SEC_RED:   base = neg_q ? DegWrap : '0;
      SEC_GREEN: base = DegGreen;
      SEC_BLUE:  base = DegBlue;
      default:   base = '0;
    endcase
    deg   = neg_q ? (base - {1'b0, fin.h_quo}) : (base + {1'b0, fin.h_quo});
    hue_c = grey ? '0 : deg[8:1];
    sat_c = grey ? '0 : fin.s_quo;

    out_d.skin       = (hue_c >= hue_low_q) && (hue_c <= hue_high_q) &&
                       (sat_c >= sat_low_q) && (sat_c <= sat_high_q) &&
                       (fin.mx >= val_low_q) && (fin.mx <= val_high_q);
    out_d.hue        = hue_c;
    out_d.saturation = sat_c;
    out_d.brightness = fin.mx;
    out_d.last_out   = fin.last;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NStg-1] && v_q[NStg-2]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---- assertions ----
  `RSKIN_ASSERT_IMP(a_hue_range, out_valid_o, out_data_o.hue <= HueMax,
                    "hue above 179")
  `RSKIN_ASSERT_IMP(a_grey_hue, out_valid_o && (out_data_o.saturation == '0),
                    out_data_o.hue == '0, "zero saturation with non-zero hue")
  `RSKIN_ASSERT_IMP(a_bright_align, out_valid_o, out_data_o.brightness[1:0] == 2'b00,
                    "brightness not an expanded channel value")
  `RSKIN_ASSERT_NXT(a_stage_hold, v_q[0] && !rdy[1], v_q[0],
                    "first stage lost an item while blocked")

endmodule

// ----- tb/skin_pixel_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skin_pixel_checker
// Watches both pixel channels of the classifier. On every input transfer
// it works out the HSV values and the skin verdict under its own copy of
// the window registers, and compares each output transfer field by field
// with the oldest prediction.
// ---------------------------------------------------------------------------
module skin_pixel_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  rskin_pkg::pix_in_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  rskin_pkg::pix_out_t            out_data_i,
  input  logic                           cfg_we_i,
  input  logic [rskin_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rskin_pkg::CfgDataW-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import rskin_pkg::*;

  logic [7:0] window_reg [6];
  pix_out_t   expected_px_q [$];

  function automatic bit in_window(input int x, input logic [7:0] lo, input logic [7:0] hi);
    return (x >= int'(lo)) && (x <= int'(hi));
  endfunction

  function automatic pix_out_t classify_pixel(input pix_in_t px);
    pix_out_t res;
    int r, g, b, mx, mn, delta, deg, hue, sat;
    r = int'(px.pixel[15:11]) * 8;
    g = int'(px.pixel[10:5]) * 4;
    b = int'(px.pixel[4:0]) * 8;
    mx = (r >= g) ? r : g;
    if (b > mx) mx = b;
    mn = (r <= g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    sat = 0;
    if (delta != 0) begin
      sat = (255 * delta) / mx;
      // sector order red, green, blue: ties go to the earlier channel
      if (mx == r) begin
        deg = (60 * (g - b)) / delta;
        if (deg < 0) deg += int'(DegWrap);
      end else if (mx == g) begin
        deg = (60 * (b - r)) / delta + int'(DegGreen);
      end else begin
        deg = (60 * (r - g)) / delta + int'(DegBlue);
      end
      hue = deg / 2;
    end
    res.skin = in_window(hue, window_reg[REG_HUE_LOW], window_reg[REG_HUE_HIGH]) &&
               in_window(sat, window_reg[REG_SAT_LOW], window_reg[REG_SAT_HIGH]) &&
               in_window(mx, window_reg[REG_VAL_LOW], window_reg[REG_VAL_HIGH]);
    res.hue        = 8'(hue);
    res.saturation = 8'(sat);
    res.brightness = 8'(mx);
    res.last_out   = px.last_in;
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      expected_px_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      window_reg[REG_HUE_LOW]  = HueLowRst;
      window_reg[REG_HUE_HIGH] = HueHighRst;
      window_reg[REG_SAT_LOW]  = SatLowRst;
      window_reg[REG_SAT_HIGH] = SatHighRst;
      window_reg[REG_VAL_LOW]  = ValLowRst;
      window_reg[REG_VAL_HIGH] = ValHighRst;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_px_q.size() == 0) begin
          $display("%0t: unexpected output transfer, expected none, got %h", $time,
                   out_data_i);
          fail_count_o++;
        end else begin
          want = expected_px_q.pop_front();
          check_field("skin", want.skin, out_data_i.skin);
          check_field("hue", want.hue, out_data_i.hue);
          check_field("saturation", want.saturation, out_data_i.saturation);
          check_field("brightness", want.brightness, out_data_i.brightness);
          check_field("last_out", want.last_out, out_data_i.last_out);
        end
      end
      if (in_valid_i && !in_stall_i) expected_px_q.push_back(classify_pixel(in_data_i));
      // indexes above the last register are dropped by the block
      if (cfg_we_i && (cfg_idx_i <= REG_VAL_HIGH)) window_reg[cfg_idx_i] = cfg_data_i;
      pending_o = expected_px_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Pixel stream stimulus for the RGB565 skin classifier: directed corner
// pixels, then random pixels weighted towards grey and tied channels, under
// a range of window settings and stall patterns on both channels.
// ---------------------------------------------------------------------------
module testbench;
  import rskin_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 12;
  localparam logic [CfgIdxW-1:0] UnusedIdxA = 3'd6;
  localparam logic [CfgIdxW-1:0] UnusedIdxB = 3'd7;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  pix_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pix_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int cycle_cnt     = 0;
  int src_idle_pct  = 0;
  int dst_stall_pct = 0;
  int items_sent    = 0;
  int config_sets   = 1;

  // corner pixels: black, white, greys, primaries, tied maxima, wrapped red hue
  logic [16:0] directed_px [20] = '{
    {16'h0000, 1'b0}, {16'hFFFF, 1'b1}, {16'h0841, 1'b0}, {16'h8410, 1'b0},
    {16'hF800, 1'b0}, {16'h07E0, 1'b0}, {16'h001F, 1'b0}, {16'hF81F, 1'b0},
    {16'hFFC0, 1'b0}, {16'h07DF, 1'b0}, {16'hF810, 1'b0}, {16'h0800, 1'b1},
    {16'hFA8A, 1'b0}, {16'hC4A6, 1'b0}, {16'h0020, 1'b0}, {16'h0001, 1'b0},
    {16'hFFDF, 1'b1}, {16'h7BEF, 1'b0}, {16'hF7DE, 1'b0}, {16'h8000, 1'b1}
  };

  rgb565_skin_pixel_classifier_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  skin_pixel_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  // mostly uniform pixels; the rest grey or with two channels tied
  function automatic logic [15:0] random_pixel();
    logic [4:0] v;
    logic [4:0] lo;
    v  = 5'($urandom_range(31));
    lo = 5'($urandom_range(int'(v)));
    case ($urandom_range(9))
      7:       return {v, v, 1'b0, v};
      8:       return {v, v, 1'b0, 5'($urandom_range(31))};
      9:       return {$urandom_range(1) ? lo : 5'($urandom_range(31)), v, 1'b0, v};
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_pixel(input pix_in_t px);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    items_sent++;
  endtask

  task automatic run_pixels(input int n);
    pix_in_t px;
    repeat (n) begin
      px.pixel   = random_pixel();
      px.last_in = ($urandom_range(15) == 0);
      send_pixel(px);
    end
  endtask

  // hold the input off until every predicted result has been transferred
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic load_windows(input logic [7:0] hl, input logic [7:0] hh,
                              input logic [7:0] sl, input logic [7:0] sh,
                              input logic [7:0] vl, input logic [7:0] vh);
    write_reg(REG_HUE_LOW, hl);
    write_reg(REG_HUE_HIGH, hh);
    write_reg(REG_SAT_LOW, sl);
    write_reg(REG_SAT_HIGH, sh);
    write_reg(REG_VAL_LOW, vl);
    write_reg(REG_VAL_HIGH, vh);
    config_sets++;
  endtask

  initial begin
    src_idle_pct  = 11;
    dst_stall_pct = 59;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset windows first
    foreach (directed_px[i]) send_pixel(pix_in_t'(directed_px[i]));
    wait_drained();

    load_windows(8'd0, 8'd25, 8'd20, 8'd180, 8'd50, 8'd250);
    write_reg(UnusedIdxA, 8'($urandom_range(255)));
    write_reg(UnusedIdxB, 8'($urandom_range(255)));
    run_pixels(275);
    wait_drained();
    run_pixels(275);
    wait_drained();

    src_idle_pct  = 59;
    dst_stall_pct = 11;
    load_windows(8'd0, HueMax, 8'd0, 8'd255, 8'd0, 8'd255);
    run_pixels(275);
    wait_drained();
    // inverted windows: nothing may be classed as skin
    load_windows(HueMax, 8'd0, 8'd200, 8'd15, 8'd255, 8'd40);
    run_pixels(275);
    wait_drained();

    src_idle_pct  = 0;
    dst_stall_pct = 0;
    load_windows(HueMax, HueMax, 8'd255, 8'd255, 8'd255, 8'd255);
    run_pixels(100);
    wait_drained();
    load_windows(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_pixels(100);
    wait_drained();
    repeat (4) begin
      load_windows(8'($urandom_range(179)), 8'($urandom_range(179)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      run_pixels(100);
      wait_drained();
    end

    $display("%0d pixels checked under %0d window settings, with stalls on either side",
             items_sent, config_sets);
    $display("and a free-running part; greys, tied maxima and wrapped red hues included");
    if ((fail_count == 0) && (pending == 0)) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
